### rtl/ffa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ffa_pkg;

    // field widths
    localparam int BASE_W      = 10;
    localparam int SIZE_W      = 11;
    localparam int START_W     = 10;
    localparam int LEN_W       = 11;
    localparam int GRANT_W     = 10;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 11;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_SIZE   = 1'b1;

    // register reset values
    localparam logic [BASE_W-1:0] BASE_RESET = 10'd10;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1014;

    // item modes
    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture accepted item
        logic scan;     // run the occupancy scan
        logic wr_step;  // one step of the write sweep
        logic push;     // move result into the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic hit;        // free run found
        logic miss;       // scan ended without a run
        logic len_zero;   // requested length is zero
        logic wr_done;    // write sweep reached its end
        logic slot_free;  // output register can take a result
    } t_status;

endpackage

`default_nettype wire

### rtl/ffa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ffa_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic            i_in_mode,
    output logic                 o_in_ready,
    input  wire ffa_pkg::t_status i_st,
    output ffa_pkg::t_cmd        o_cmd
);
    import ffa_pkg::*;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_SCAN  = 6'b000100,
        ST_MARK  = 6'b001000,
        ST_FREE  = 6'b010000,
        ST_REPLY = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // next state and commands
    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.wr_step = 1'b1;
                if (i_st.wr_done) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    n_state = (i_in_mode == MODE_RELEASE) ? ST_FREE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_st.hit) begin
                    n_state = i_st.len_zero ? ST_REPLY : ST_MARK;
                end else if (i_st.miss) begin
                    n_state = ST_REPLY;
                end
            end
            ST_MARK, ST_FREE: begin
                o_cmd.wr_step = 1'b1;
                if (i_st.wr_done) n_state = ST_REPLY;
            end
            ST_REPLY: begin
                o_cmd.push = 1'b1;
                if (i_st.slot_free) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

### rtl/ffa_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module ffa_datapath #(
    parameter int CELL_COUNT = 1024
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [ffa_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [ffa_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic [ffa_pkg::IN_TDATA_W-1:0]     i_in_tdata,
    input  wire logic                               i_in_tuser,
    input  wire ffa_pkg::t_cmd                      i_cmd,
    output ffa_pkg::t_status                        o_st,
    input  wire logic                               i_out_tready,
    output logic                                    o_out_tvalid,
    output logic [ffa_pkg::OUT_TDATA_W-1:0]         o_out_tdata,
    output logic                                    o_out_tuser
);
    import ffa_pkg::*;

    localparam int AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int CW = (AW + 1 > 12) ? AW + 1 : 12;
    localparam logic [CW-1:0] CELLS = CW'(CELL_COUNT);

    // occupancy store
    logic r_mem [CELL_COUNT];

    // configuration
    logic [BASE_W-1:0]  r_base;
    logic [SIZE_W-1:0]  r_size;

    // item and scan state
    logic [LEN_W-1:0]   r_len;
    logic [CW-1:0]      r_rd_idx;
    logic [CW-1:0]      r_end;
    logic               r_q_valid;
    logic [CW-1:0]      r_q_idx;
    logic               r_q_data;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_first;

    // write sweep
    logic [CW-1:0]      r_wr_idx;
    logic [CW-1:0]      r_wr_end;
    logic               r_wr_bit;

    // result and output register
    logic               r_res_ok;
    logic [GRANT_W-1:0] r_res_start;
    logic               r_out_valid;
    logic               r_out_ok;
    logic [GRANT_W-1:0] r_out_start;

    logic [START_W-1:0] w_item_start;
    logic [LEN_W-1:0]   w_item_len;
    logic [CW-1:0]      w_win_sum;
    logic [CW-1:0]      w_win_end;
    logic [CW-1:0]      w_rel_sum;
    logic [CW-1:0]      w_rel_end;
    logic               w_rd_more;
    logic [CW-1:0]      w_cnt_nx;
    logic [CW-1:0]      w_first_nx;
    logic               w_reach;
    logic               w_hit;
    logic               w_miss;
    logic               w_wr_done;
    logic               w_mem_we;
    logic               w_slot_free;

    assign w_item_start = i_in_tdata[START_W-1:0];
    assign w_item_len   = i_in_tdata[START_W +: LEN_W];

    // scan window end, clamped to the store
    assign w_win_sum = CW'(r_base) + CW'(r_size);
    assign w_win_end = (w_win_sum > CELLS) ? CELLS : w_win_sum;

    // release end, clamped to the store
    assign w_rel_sum = CW'(w_item_start) + CW'(w_item_len);
    assign w_rel_end = (w_rel_sum > CELLS) ? CELLS : w_rel_sum;

    // evaluate the cell that came back from the store
    assign w_rd_more  = (r_rd_idx < r_end);
    assign w_cnt_nx   = r_q_data ? '0 : r_count + CW'(1);
    assign w_first_nx = (!r_q_data && (r_count == '0)) ? r_q_idx : r_first;
    assign w_reach    = r_q_valid && (w_cnt_nx >= CW'(r_len));
    assign w_hit      = w_reach && !r_q_data;
    assign w_miss     = (w_reach && r_q_data) || (!r_q_valid && !w_rd_more);

    assign w_wr_done   = (r_wr_idx >= r_wr_end);
    assign w_mem_we    = i_cmd.wr_step && !w_wr_done;
    assign w_slot_free = !r_out_valid || i_out_tready;

    assign o_st.hit       = w_hit;
    assign o_st.miss      = w_miss;
    assign o_st.len_zero  = (r_len == '0);
    assign o_st.wr_done   = w_wr_done;
    assign o_st.slot_free = w_slot_free;

    assign o_out_tvalid = r_out_valid;
    assign o_out_tuser  = r_out_ok;
    assign o_out_tdata  = {{(OUT_TDATA_W - GRANT_W){1'b0}}, r_out_start};

    // store access: at most one write and one read address per cycle
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_wr_idx[AW-1:0]] <= r_wr_bit;
        end
        r_q_data <= r_mem[r_rd_idx[AW-1:0]];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= BASE_RESET;
            r_size      <= SIZE_RESET;
            r_wr_idx    <= '0;
            r_wr_end    <= CELLS;
            r_wr_bit    <= 1'b0;
            r_q_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_RESERVED_BASE: r_base <= i_cfg_data[BASE_W-1:0];
                    CFG_REGION_SIZE:   r_size <= i_cfg_data[SIZE_W-1:0];
                    default:           r_size <= r_size;
                endcase
            end

            // write sweep range and step
            if (i_cmd.load && (i_in_tuser == MODE_RELEASE)) begin
                r_wr_idx <= CW'(w_item_start);
                r_wr_end <= w_rel_end;
                r_wr_bit <= 1'b0;
            end else if (i_cmd.scan && w_hit && (r_len != '0)) begin
                r_wr_idx <= w_first_nx;
                r_wr_end <= r_q_idx + CW'(1);
                r_wr_bit <= 1'b1;
            end else if (w_mem_we) begin
                r_wr_idx <= r_wr_idx + CW'(1);
            end

            // read pipeline valid
            r_q_valid <= i_cmd.scan && w_rd_more;

            // output register
            if (i_cmd.push && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // scan and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_len    <= w_item_len;
            r_rd_idx <= CW'(r_base);
            r_end    <= w_win_end;
            r_count  <= '0;
            r_first  <= '0;
            if (i_in_tuser == MODE_RELEASE) begin
                r_res_ok    <= 1'b1;
                r_res_start <= '0;
            end
        end else if (i_cmd.scan) begin
            if (w_rd_more) r_rd_idx <= r_rd_idx + CW'(1);
            r_q_idx <= r_rd_idx;
            if (r_q_valid) begin
                r_count <= w_cnt_nx;
                r_first <= w_first_nx;
            end
            if (w_hit) begin
                r_res_ok    <= 1'b1;
                r_res_start <= w_first_nx[GRANT_W-1:0];
            end else if (w_miss) begin
                r_res_ok    <= 1'b0;
                r_res_start <= '0;
            end
        end

        if (i_cmd.push && w_slot_free) begin
            r_out_ok    <= r_res_ok;
            r_out_start <= r_res_start;
        end
    end

endmodule

`default_nettype wire

### rtl/first_fit_block_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake                 payload
// s_axis    in   s_axis_tvalid/tready      tdata: run_start, run_length; tuser: mode
// m_axis    out  m_axis_tvalid/tready      tdata: granted_start; tuser: success
// cfg       in   i_cfg_we                  i_cfg_idx, i_cfg_data
//
// one item at a time; the occupancy store sets the pace, one cell per cycle
// allocate: a scan of the window, then a write sweep over the granted run, then the result
// release: a write sweep over the released cells, then the result
// after reset a clearing pass over the whole store runs before the first item
// a result waiting on m_axis holds the next item only when that item is done

module first_fit_block_allocator #(
    parameter int CELL_COUNT = 1024
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [ffa_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [ffa_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [9:0] run_start, [20:10] run_length, [23:21] zero
    input  wire logic [ffa_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [0] mode
    input  wire logic                               s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [9:0] granted_start, [15:10] zero
    output logic [ffa_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    // [0] success
    output logic                                    m_axis_tuser
);
    import ffa_pkg::*;

    t_cmd    w_cmd;
    t_status w_st;

    ffa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_mode  (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_st       (w_st),
        .o_cmd      (w_cmd)
    );

    ffa_datapath #(
        .CELL_COUNT (CELL_COUNT)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_tdata   (s_axis_tdata),
        .i_in_tuser   (s_axis_tuser),
        .i_cmd        (w_cmd),
        .o_st         (w_st),
        .i_out_tready (m_axis_tready),
        .o_out_tvalid (m_axis_tvalid),
        .o_out_tdata  (m_axis_tdata),
        .o_out_tuser  (m_axis_tuser)
    );

    // only one item in flight
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in flight");

    // a failed result carries a zero start
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("failed result with nonzero start");

    // scan cannot end both ways at once
    a_hit_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.scan |-> !(w_st.hit && w_st.miss))
        else $error("scan hit and miss together");

    // a stalled reply keeps waiting
    a_reply_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.push && !w_st.slot_free |=> w_cmd.push)
        else $error("reply dropped while output busy");

endmodule

`default_nettype wire

### test/tb_first_fit_block_allocator.sv
`timescale 1ns / 1ps

module tb_first_fit_block_allocator;

    import ffa_pkg::*;

    localparam int CELLS          = 1024;
    localparam int QUIET_LIMIT    = 16384;
    localparam int TAIL_CYCLES    = 2 * CELLS + 16;

    typedef struct packed {
        logic               success;
        logic [GRANT_W-1:0] granted_start;
    } t_grant_result;

    typedef struct {
        int first;
        int len;
    } t_run;

    // block ports
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = CFG_RESERVED_BASE;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [9:0] run_start, [20:10] run_length, [23:21] zero
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    // [0] mode
    logic                   s_axis_tuser = MODE_ALLOC;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [9:0] granted_start, [15:10] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // [0] success
    logic                   m_axis_tuser;

    // occupancy mirror and register copies
    bit                     cell_busy [CELLS];
    logic [BASE_W-1:0]      base_reg = BASE_RESET;
    logic [SIZE_W-1:0]      size_reg = SIZE_RESET;

    t_grant_result          grant_expect_q [$];
    t_grant_result          head_res;
    t_run                   live_runs [$];

    int                     src_idle_pct = 0;
    int                     sink_stall_pct = 0;
    int                     sent_count = 0;
    int                     done_count = 0;
    int                     fail_count = 0;
    int                     quiet_cycles = 0;

    first_fit_block_allocator #(
        .CELL_COUNT(CELLS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 i_clk = ~i_clk;

    // first-fit search or release on the occupancy mirror
    function automatic t_grant_result predict_grant(input logic mode,
                                                    input logic [START_W-1:0] start,
                                                    input logic [LEN_W-1:0] len);
        t_grant_result res;
        int stop;
        int cnt;
        int first_free;
        bit found;
        res = '0;
        if (mode == MODE_RELEASE) begin
            stop = int'(start) + int'(len);
            if (stop > CELLS) stop = CELLS;
            for (int i = int'(start); i < stop; i++) cell_busy[i] = 1'b0;
            res.success = 1'b1;
        end else begin
            stop = int'(base_reg) + int'(size_reg);
            if (stop > CELLS) stop = CELLS;
            cnt = 0;
            first_free = 0;
            found = 1'b0;
            for (int i = int'(base_reg); i < stop; i++) begin
                if (cell_busy[i]) begin
                    cnt = 0;
                    found = 1'b0;
                end else begin
                    if (cnt == 0) begin
                        first_free = i;
                        found = 1'b1;
                    end
                    cnt++;
                end
                if (cnt >= int'(len)) begin
                    if (found) begin
                        for (int k = 0; k < int'(len); k++) cell_busy[first_free + k] = 1'b1;
                        res.success = 1'b1;
                        res.granted_start = first_free[GRANT_W-1:0];
                    end
                    break;
                end
            end
        end
        return res;
    endfunction

    // input transfer: predict and remember allocated runs
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            head_res = predict_grant(s_axis_tuser, s_axis_tdata[9:0], s_axis_tdata[20:10]);
            grant_expect_q.push_back(head_res);
            if (s_axis_tuser == MODE_ALLOC && head_res.success && s_axis_tdata[20:10] != 0)
                live_runs.push_back('{int'(head_res.granted_start),
                                      int'(s_axis_tdata[20:10])});
        end
    end

    // output transfer: compare with oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            done_count++;
            if (grant_expect_q.size() == 0) begin
                $error("unexpected result: success %0b granted_start %0d",
                       m_axis_tuser, m_axis_tdata[9:0]);
                fail_count++;
            end else begin
                head_res = grant_expect_q.pop_front();
                if (m_axis_tuser !== head_res.success) begin
                    $error("success: expected %0b, actual %0b", head_res.success, m_axis_tuser);
                    fail_count++;
                end
                if (m_axis_tdata[9:0] !== head_res.granted_start) begin
                    $error("granted_start: expected %0d, actual %0d",
                           head_res.granted_start, m_axis_tdata[9:0]);
                    fail_count++;
                end
            end
        end
    end

    // receiver backpressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("Some tests failed");
        $finish;
    end

    task automatic send_item(input logic mode, input int start, input int len);
        logic [START_W-1:0] start_bits;
        logic [LEN_W-1:0]   len_bits;
        start_bits = start[START_W-1:0];
        len_bits = len[LEN_W-1:0];
        if ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b000, len_bits, start_bits};
        s_axis_tuser <= mode;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent_count++;
    endtask

    task automatic wait_results_idle();
        s_axis_tvalid <= 1'b0;
        while (done_count < sent_count) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // both registers, back to back, only while idle
    task automatic write_cfg(input logic [CFG_DATA_W-1:0] base_word,
                             input logic [CFG_DATA_W-1:0] size_word);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_RESERVED_BASE;
        i_cfg_data <= base_word;
        @(posedge i_clk);
        i_cfg_idx <= CFG_REGION_SIZE;
        i_cfg_data <= size_word;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        base_reg = base_word[BASE_W-1:0];
        size_reg = size_word[SIZE_W-1:0];
    endtask

    // reset window: zero length, fill, overflow, release past the end
    task automatic test_reset_window();
        send_item(MODE_ALLOC, 0, 0);
        send_item(MODE_ALLOC, 0, 5);
        send_item(MODE_ALLOC, 0, 0);
        send_item(MODE_ALLOC, 0, 1024);
        send_item(MODE_ALLOC, 1023, 2047);
        send_item(MODE_RELEASE, 10, 5);
        send_item(MODE_ALLOC, 0, 1014);
        send_item(MODE_ALLOC, 0, 1);
        send_item(MODE_RELEASE, 1020, 2047);
        send_item(MODE_RELEASE, 0, 1024);
        send_item(MODE_RELEASE, 0, 0);
        send_item(MODE_ALLOC, 682, 3);
        wait_results_idle();
    endtask

    // window of one cell at the top of the store
    task automatic test_single_cell_window();
        write_cfg(11'd1023, 11'd1);
        send_item(MODE_ALLOC, 0, 1);
        send_item(MODE_ALLOC, 0, 0);
        send_item(MODE_RELEASE, 1023, 1);
        send_item(MODE_ALLOC, 0, 0);
        send_item(MODE_ALLOC, 0, 2);
        wait_results_idle();
    endtask

    // zero region size: every request fails
    task automatic test_empty_window();
        write_cfg(11'd5, 11'd0);
        send_item(MODE_ALLOC, 0, 0);
        send_item(MODE_ALLOC, 0, 1);
        wait_results_idle();
    endtask

    // whole store as window, size beyond the end is clamped
    task automatic test_full_store_window();
        write_cfg(11'd0, 11'd2047);
        send_item(MODE_RELEASE, 0, 1024);
        send_item(MODE_ALLOC, 0, 1024);
        send_item(MODE_RELEASE, 0, 1024);
        wait_results_idle();
        live_runs.delete();
    endtask

    // mostly real alloc and release pairs, some stray releases
    task automatic test_random_traffic(input int n_items, input int src_pct, input int sink_pct,
                                       input logic [CFG_DATA_W-1:0] base_word,
                                       input logic [CFG_DATA_W-1:0] size_word);
        int roll;
        int pick;
        int len;
        t_run run;
        write_cfg(base_word, size_word);
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        repeat (n_items) begin
            roll = $urandom_range(99);
            if (roll < 45) begin
                pick = $urandom_range(99);
                if (pick < 8) len = 0;
                else if (pick < 90) len = $urandom_range(24, 1);
                else if (pick < 97) len = $urandom_range(300, 25);
                else len = $urandom_range(2047, 301);
                send_item(MODE_ALLOC, $urandom_range(1023), len);
            end else if (roll < 85 && live_runs.size() != 0) begin
                pick = $urandom_range(live_runs.size() - 1);
                run = live_runs[pick];
                live_runs.delete(pick);
                send_item(MODE_RELEASE, run.first, run.len);
            end else if (roll < 95) begin
                send_item(MODE_RELEASE, $urandom_range(1023), $urandom_range(40));
            end else begin
                send_item(MODE_RELEASE, $urandom_range(1023), $urandom_range(2047));
            end
        end
        wait_results_idle();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_window();
        test_single_cell_window();
        test_empty_window();
        test_full_store_window();
        test_random_traffic(190, 11, 76, 11'($urandom_range(63)), 11'($urandom_range(1024, 200)));
        test_random_traffic(190, 76, 11, {1'($urandom_range(1)), 10'($urandom_range(1023, 512))},
                            11'd2047);
        test_random_traffic(190, 0, 0, 11'(BASE_RESET), SIZE_RESET);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && grant_expect_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### filelist.f
rtl/ffa_pkg.sv
rtl/ffa_ctrl.sv
rtl/ffa_datapath.sv
rtl/first_fit_block_allocator.sv
test/tb_first_fit_block_allocator.sv
